// ===== design/ttm_pkg.sv =====
// Package for the timer table manager: payload structs, op and status codes.
// Used by timer_table_manager; depends on nothing.
package ttm_pkg;

    localparam int TimerSlots = 32;
    localparam int IdxW = $clog2(TimerSlots);
    localparam int CntW = $clog2(TimerSlots + 1);
    localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] ThinkPeriodReset = 32'd100000;
    localparam logic [31:0] IdleStepReset    = 32'd15000;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_ADD      = 3'd1;
    localparam logic [2:0] OP_KILL     = 3'd2;
    localparam logic [2:0] OP_PURGE_OW = 3'd3;
    localparam logic [2:0] OP_PURGE_MC = 3'd4;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_KILLED   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_PURGED   = 3'd4;
    localparam logic [2:0] ST_FIRED    = 3'd5;
    localparam logic [2:0] ST_IDLE     = 3'd6;

    localparam logic CFG_THINK = 1'b0;
    localparam logic CFG_IDLE  = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] owner;
        logic [31:0] interval_us;
        logic        repeating;
        logic        no_mapchange;
        logic [4:0]  handle;
        logic        simulating;
        logic [31:0] elapsed_us;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  timer_handle;
        logic [15:0] timer_owner;
        logic        fired_repeating;
        logic [5:0]  purged_count;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [47:0] expiry;
        logic [31:0] period;
        logic        no_mapchange;
        logic        repeating;
        logic [4:0]  handle;
        logic [15:0] owner;
    } entry_t;

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? TimeMax : s[47:0];
    endfunction

endpackage

// ===== design/timer_table_manager.sv =====
// Timer table manager: ordered timer table held in one synchronous memory.
// Work per accepted word: an add, or a tick before think time, goes straight to its
// final word; kill and purge make one table pass, reading then processing each entry;
// a scanning tick makes a one-shot fire pass, a repeating fire pass and a compaction pass.
// Output stalls lengthen these. A new word is taken the cycle after the final word is
// loaded, so one word is finished before the next is accepted.
// Reset clears the count, handle map, clock and registers; the memory is not cleared.
module timer_table_manager (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ttm_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ttm_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);
    import ttm_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ADD, S_READ, S_PROC, S_FINAL} state_t;
    typedef enum logic [1:0] {PASS_ONESHOT, PASS_REPEAT, PASS_COMPACT} pass_t;

    entry_t          mem [TimerSlots];
    entry_t          rd_data_reg;
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    entry_t          wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    state_t          state_reg, state_next;
    in_word_t        item_reg, item_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [31:0]     free_reg, free_next;
    logic [47:0]     now_reg, now_next;
    logic [47:0]     think_reg, think_next;
    logic [31:0]     think_per_reg, think_per_next;
    logic [31:0]     idle_step_reg, idle_step_next;
    logic            out_valid_reg, out_valid_next;
    out_word_t       out_reg, out_next;
    logic [CntW-1:0] idx_reg, idx_next;   // descending passes count the entries left
    logic [CntW-1:0] dst_reg, dst_next;   // compaction write pointer
    logic [CntW-1:0] purged_reg, purged_next;
    pass_t           pass_reg, pass_next;
    logic            found_reg, found_next;
    logic            hold_valid_reg, hold_valid_next;
    out_word_t       hold_reg, hold_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    logic            drop;
    logic            fire;
    logic            stall;
    logic            can_emit;
    logic            walk_done;
    logic [4:0]      free_h;
    logic            free_ok;
    logic [47:0]     tick_now;
    logic [IdxW-1:0] cur_idx;
    out_word_t       fire_word;

    always_comb
    begin
        free_h  = '0;
        free_ok = 1'b0;
        for (int i = 31; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                free_h  = 5'(i);
                free_ok = 1'b1;
            end
        end
        tick_now = sat_add48(now_reg,
            in_data.simulating ? in_data.elapsed_us : idle_step_reg);
    end

    // Fire passes walk down from the top; compaction walks up.
    assign cur_idx   = (pass_reg == PASS_COMPACT) ? IdxW'(idx_reg)
                                                  : IdxW'(idx_reg - 1'b1);
    assign walk_done = (pass_reg == PASS_COMPACT) ? (idx_reg == count_reg)
                                                  : (idx_reg == '0);
    assign can_emit  = !out_valid_reg || out_ready;

    always_comb
    begin
        case (item_reg.op)
            OP_KILL:     drop = !found_reg && rd_data_reg.handle == item_reg.handle;
            OP_PURGE_OW: drop = rd_data_reg.owner == item_reg.owner;
            OP_PURGE_MC: drop = rd_data_reg.no_mapchange;
            default:     drop = !rd_data_reg.repeating && now_reg >= rd_data_reg.expiry;
        endcase
        fire = (rd_data_reg.repeating == (pass_reg == PASS_REPEAT))
               && now_reg >= rd_data_reg.expiry;
        fire_word                 = '0;
        fire_word.status          = ST_FIRED;
        fire_word.timer_handle    = rd_data_reg.handle;
        fire_word.timer_owner     = rd_data_reg.owner;
        fire_word.fired_repeating = rd_data_reg.repeating;
    end

    // A fired word waits in the hold register until the next one shows up, so the
    // final word of a tick can carry last.
    assign stall = (state_reg == S_PROC) && (pass_reg != PASS_COMPACT) && fire
                   && hold_valid_reg && !can_emit;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        count_next      = count_reg;
        free_next       = free_reg;
        now_next        = now_reg;
        think_next      = think_reg;
        think_per_next  = think_per_reg;
        idle_step_next  = idle_step_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        idx_next        = idx_reg;
        dst_next        = dst_reg;
        purged_next     = purged_reg;
        pass_next       = pass_reg;
        found_next      = found_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        rd_en   = 1'b0;
        rd_addr = cur_idx;
        wr_en   = 1'b0;
        wr_addr = cur_idx;
        wr_data = rd_data_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_THINK: think_per_next = cfg_data;
                CFG_IDLE:  idle_step_next = cfg_data;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next       = in_data;
                    idx_next        = '0;
                    dst_next        = '0;
                    purged_next     = '0;
                    found_next      = 1'b0;
                    hold_valid_next = 1'b0;
                    pass_next       = PASS_COMPACT;
                    case (in_data.op) inside
                        OP_ADD:
                            state_next = S_ADD;
                        OP_TICK:
                        begin
                            now_next = tick_now;
                            if (tick_now >= think_reg)
                            begin
                                pass_next  = PASS_ONESHOT;
                                idx_next   = count_reg;
                                state_next = S_READ;
                            end
                            else
                                state_next = S_FINAL;
                        end
                        OP_KILL, OP_PURGE_OW, OP_PURGE_MC:
                            state_next = S_READ;
                        default: ;
                    endcase
                end
            end
            S_ADD:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.last  = 1'b1;
                    if (count_reg < CntW'(TimerSlots) && free_ok)
                    begin
                        wr_en                = 1'b1;
                        wr_addr              = IdxW'(count_reg);
                        wr_data.expiry       = sat_add48(now_reg, item_reg.interval_us);
                        wr_data.period       = item_reg.interval_us;
                        wr_data.owner        = item_reg.owner;
                        wr_data.handle       = free_h;
                        wr_data.repeating    = item_reg.repeating;
                        wr_data.no_mapchange = item_reg.no_mapchange;
                        free_next[free_h]     = 1'b0;
                        count_next            = count_reg + 1'b1;
                        out_next.status       = ST_ADDED;
                        out_next.timer_handle = free_h;
                    end
                    else
                        out_next.status = ST_FULL;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                if (walk_done)
                begin
                    unique case (pass_reg)
                        PASS_ONESHOT:
                        begin
                            pass_next = PASS_REPEAT;
                            idx_next  = count_reg;
                        end
                        PASS_REPEAT:
                        begin
                            pass_next = PASS_COMPACT;
                            idx_next  = '0;
                        end
                        default:
                        begin
                            count_next = dst_reg;
                            if (item_reg.op == OP_TICK)
                                think_next = sat_add48(now_reg, think_per_reg);
                            state_next = S_FINAL;
                        end
                    endcase
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                if (pass_reg == PASS_COMPACT)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_READ;
                    if (drop)
                    begin
                        free_next[rd_data_reg.handle] = 1'b1;
                        purged_next = purged_reg + 1'b1;
                        found_next  = 1'b1;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = IdxW'(dst_reg);
                        dst_next = dst_reg + 1'b1;
                    end
                end
                else if (!stall)
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_READ;
                    if (fire)
                    begin
                        if (pass_reg == PASS_REPEAT)
                        begin
                            wr_en          = 1'b1;
                            wr_data.expiry = sat_add48(now_reg, rd_data_reg.period);
                        end
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = hold_reg;
                        end
                        hold_valid_next = 1'b1;
                        hold_next       = fire_word;
                    end
                end
            end
            S_FINAL:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    case (item_reg.op) inside
                        OP_KILL:
                        begin
                            out_next.status       = found_reg ? ST_KILLED : ST_NOTFOUND;
                            out_next.timer_handle = item_reg.handle;
                        end
                        OP_PURGE_OW, OP_PURGE_MC:
                        begin
                            out_next.status       = ST_PURGED;
                            out_next.purged_count = purged_reg;
                        end
                        default:
                        begin
                            if (hold_valid_reg)
                                out_next = hold_reg;
                            else
                                out_next.status = ST_IDLE;
                        end
                    endcase
                    out_next.last   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            count_reg      <= '0;
            free_reg       <= '1;
            now_reg        <= '0;
            think_reg      <= '0;
            think_per_reg  <= ThinkPeriodReset;
            idle_step_reg  <= IdleStepReset;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            idx_reg        <= '0;
            dst_reg        <= '0;
            purged_reg     <= '0;
            pass_reg       <= PASS_COMPACT;
            found_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            item_reg       <= item_next;
            count_reg      <= count_next;
            free_reg       <= free_next;
            now_reg        <= now_next;
            think_reg      <= think_next;
            think_per_reg  <= think_per_next;
            idle_step_reg  <= idle_step_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
            idx_reg        <= idx_next;
            dst_reg        <= dst_next;
            purged_reg     <= purged_next;
            pass_reg       <= pass_next;
            found_reg      <= found_next;
            hold_valid_reg <= hold_valid_next;
            hold_reg       <= hold_next;
        end
    end
endmodule
